// ===== design/rlcre_pkg.sv =====
// Shared types, constants and cost helpers for the run/level rate estimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlcre_pkg;

    localparam int COEF_W    = 16;
    localparam int RUN_W     = 10;
    localparam int PART_W    = 6;   // one level or run cost, max 34
    localparam int COST_W    = 7;   // level + run cost, max 66
    localparam int TOTAL_W   = 12;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [3:0]        ORDER_CAP  = 4'd11;
    localparam logic [16:0]       ORDER_SAT  = 17'd4096;
    localparam logic [COEF_W-1:0] LEVEL_ESC  = 16'd9;
    localparam logic [PART_W-1:0] LEVEL_BASE = 6'd10;
    localparam logic [RUN_W-1:0]  RUN_ESC    = 10'd16;
    localparam logic [PART_W-1:0] RUN_BASE   = 6'd16;

    // one classified pair handed from front to back
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              last;
    } pair_cost_t;

    // floor(log2(x + 1)), saturated at ORDER_CAP
    function automatic logic [3:0] eg_order(input logic [COEF_W-1:0] x);
        logic [16:0] v;
        logic [3:0]  n;
        v = {1'b0, x} + 17'd1;
        n = 4'd0;
        if (v >= ORDER_SAT) begin
            n = ORDER_CAP;
        end
        else begin
            for (int i = 1; i < 12; i++) begin
                if (v[i]) begin
                    n = 4'(i);
                end
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/rlcre_front.sv =====
// Front end: accepts pairs, computes the level and run cost, registers it.
// Depends on rlcre_pkg.
`default_nettype none

module rlcre_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [rlcre_pkg::COEF_W-1:0] coef_value,
    input  wire logic [rlcre_pkg::RUN_W-1:0]  zero_run,
    input  wire logic                       last_pair,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output rlcre_pkg::pair_cost_t           out_pair
);
    import rlcre_pkg::*;

    logic                valid_reg, valid_next;
    pair_cost_t          pair_reg, pair_next;
    logic [COEF_W-1:0]   mag;
    logic [COEF_W-1:0]   run_ext;
    logic [PART_W-1:0]   level_cost;
    logic [PART_W-1:0]   run_cost;
    logic                take;

    // -32768 maps to 32768, still fits 16 unsigned bits
    assign mag     = coef_value[COEF_W-1] ? (~coef_value + 16'd1) : coef_value;
    assign run_ext = {{(COEF_W-RUN_W){1'b0}}, zero_run};

    always_comb
    begin
        if (mag == '0) begin
            level_cost = '0;
        end
        else if (mag < LEVEL_ESC) begin
            level_cost = mag[PART_W-1:0] + 6'd2;
        end
        else begin
            level_cost = LEVEL_BASE + {1'b0, eg_order(mag - LEVEL_ESC), 1'b0};
        end
    end

    always_comb
    begin
        if (zero_run == '0) begin
            run_cost = {{(PART_W-1){1'b0}}, (mag != '0)};
        end
        else if (zero_run < RUN_ESC) begin
            run_cost = zero_run[PART_W-1:0] + 6'd1;
        end
        else begin
            run_cost = RUN_BASE
                + {1'b0, eg_order(run_ext - {{(COEF_W-RUN_W){1'b0}}, RUN_ESC}), 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        pair_next  = pair_reg;
        if (take) begin
            valid_next     = 1'b1;
            pair_next.cost = {1'b0, level_cost} + {1'b0, run_cost};
            pair_next.last = last_pair;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign out_valid = valid_reg;
    assign out_pair  = pair_reg;

endmodule

`default_nettype wire

// ===== design/rlcre_queue.sv =====
// Short queue of classified pairs between front and back.
// Depends on rlcre_pkg.
`default_nettype none

module rlcre_queue #(
    parameter int DEPTH = rlcre_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  rlcre_pkg::pair_cost_t  push_pair,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output rlcre_pkg::pair_cost_t  pop_pair
);
    import rlcre_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pair_cost_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_pair   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_pair;
        end
    end

endmodule

`default_nettype wire

// ===== design/rlcre_back.sv =====
// Back end: accumulates pair costs, emits the block total on the last pair.
// Depends on rlcre_pkg.
`default_nettype none

module rlcre_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  rlcre_pkg::pair_cost_t              in_pair,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [rlcre_pkg::TOTAL_W-1:0]      block_bits
);
    import rlcre_pkg::*;

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] sum;
    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_data_reg, out_data_next;
    logic               pop;

    // a non-last pair never needs the output slot
    assign in_ready = !in_pair.last || !out_valid_reg || out_ready;
    assign pop      = in_valid && in_ready;
    assign sum      = total_reg + {{(TOTAL_W-COST_W){1'b0}}, in_pair.cost};

    always_comb
    begin
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (pop) begin
            if (in_pair.last) begin
                total_next     = '0;
                out_valid_next = 1'b1;
                out_data_next  = sum;
            end
            else begin
                total_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign block_bits = out_data_reg;

    a_last_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop && in_pair.last |=> out_valid_reg && out_data_reg == $past(sum))
        else $error("last pair did not load block total");

    a_last_clears_total: assert property (@(posedge clk) disable iff (!rst_n)
        pop && in_pair.last |=> total_reg == '0)
        else $error("running total not cleared after last pair");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending block total overwritten while stalled");

    a_mid_pair_accumulates: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !in_pair.last |=> total_reg == $past(sum))
        else $error("pair cost not accumulated");

endmodule

`default_nettype wire

// ===== design/run_level_coef_rate_estimator_top.sv =====
// Top level of the run/level coefficient rate estimator.
// Depends on rlcre_pkg, rlcre_front, rlcre_queue and rlcre_back.
//
// Usage:
//   Slave stream (s_*) carries one (coefficient, zero run) pair per word;
//   s_tlast marks the final pair of a transform block. The master stream
//   (m_*) carries one word per block: the estimated bit cost, modulo 4096.
//   Blocks of any length are supported, the last marker alone closes one.
// Throughput: one pair per cycle sustained while m_tready does not hold back a
//   pending total; the front cost logic, the queue and the accumulator each handle one word a cycle.
// Path: a last pair passes the front register and a queue entry, then loads the
//   output register that drives m_tvalid; it waits longer while the queue is
//   full when the pair leaves the front register.
// Reset: rst_n clears the running total, the queue and all valid flags;
//   no result is pending afterwards.
// Stall: while m_tready is low, the pending total holds and non-last pairs
//   keep accumulating; a second last pair waits in the queue, and once the
//   queue and front register fill, s_tready drops.
`default_nettype none

module run_level_coef_rate_estimator_top #(
    parameter int QUEUE_DEPTH = rlcre_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rlcre_pkg::IN_DATA_W-1:0]   s_tdata,  // coef_value[15:0], zero_run[25:16]
    input  wire logic                              s_tlast,  // last_pair
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rlcre_pkg::OUT_DATA_W-1:0]       m_tdata   // block_bits[11:0]
);
    import rlcre_pkg::*;

    logic [COEF_W-1:0]  coef_value;
    logic [RUN_W-1:0]   zero_run;
    logic [TOTAL_W-1:0] block_bits;

    // front -> queue
    logic               fq_valid, fq_ready;
    pair_cost_t         fq_pair;
    // queue -> back
    logic               qb_valid, qb_ready;
    pair_cost_t         qb_pair;

    assign coef_value = s_tdata[COEF_W-1:0];
    assign zero_run   = s_tdata[COEF_W+RUN_W-1:COEF_W];

    rlcre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .coef_value (coef_value),
        .zero_run   (zero_run),
        .last_pair  (s_tlast),
        .out_valid  (fq_valid),
        .out_ready  (fq_ready),
        .out_pair   (fq_pair)
    );

    rlcre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_pair  (fq_pair),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_pair   (qb_pair)
    );

    rlcre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_pair    (qb_pair),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .block_bits (block_bits)
    );

    // upper tdata bits are padding
    assign m_tdata = {{(OUT_DATA_W-TOTAL_W){1'b0}}, block_bits};

endmodule

`default_nettype wire

// ===== test/tb_run_level_coef_rate_estimator_top.sv =====
// Self-checking testbench for run_level_coef_rate_estimator_top: streams
// coefficient/run pairs, predicts each block's bit-cost total and checks it.
// Depends on rlcre_pkg and the top-level RTL only.
`default_nettype none

module tb_run_level_coef_rate_estimator_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rlcre_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_PAIRS = 580;
    localparam int WRAP_PAIRS   = 70;   // 70 maximal-cost pairs exceed 4096
    localparam int HOLD_AT      = 25;   // totals seen before the long back-pressure
    localparam int HOLD_CYCLES  = 300;

    // cost-formula constants
    localparam int unsigned LEVEL_ESCAPE = 9;
    localparam int unsigned LEVEL_FLOOR  = 10;
    localparam int unsigned RUN_ESCAPE   = 16;
    localparam int unsigned RUN_FLOOR    = 16;
    localparam int unsigned ORDER_MAX    = 11;

    // one queued stimulus entry; a hold entry makes the sender wait for all totals
    typedef struct {
        logic [COEF_W-1:0] coef;
        logic [RUN_W-1:0]  run;
        logic              last;
        int unsigned       gap;
        bit                hold;
    } pair_word_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // coef_value[15:0], zero_run[25:16]
    logic                  s_tlast  = 1'b0; // last_pair
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // block_bits[11:0]

    pair_word_t         pending_pairs[$];
    logic [TOTAL_W-1:0] block_bits_due[$];
    logic [TOTAL_W-1:0] block_sum = '0;  // predicted running total of the open block
    int                 mismatches = 0;
    int                 totals_seen = 0;
    int                 cycles = 0;

    run_level_coef_rate_estimator_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cost predictor
    // ------------------------------------------------------------------

    // floor(log2(x + 1)), saturated
    function automatic int unsigned golomb_order(input int unsigned x);
        int unsigned v;
        int unsigned n;
        v = x + 1;
        n = 0;
        while (v > 1)
        begin
            v = v >> 1;
            n++;
        end
        return (n > ORDER_MAX) ? ORDER_MAX : n;
    endfunction

    function automatic int unsigned level_bits(input int unsigned mag);
        if (mag == 0)
            return 0;
        if (mag < LEVEL_ESCAPE)
            return mag + 2;
        return LEVEL_FLOOR + 2 * golomb_order(mag - LEVEL_ESCAPE);
    endfunction

    function automatic int unsigned run_bits(input int unsigned run, input int unsigned mag);
        if (run == 0)
            return (mag == 0) ? 0 : 1;
        if (run < RUN_ESCAPE)
            return run + 1;
        return RUN_FLOOR + 2 * golomb_order(run - RUN_ESCAPE);
    endfunction

    // fold one accepted pair into the block sum; a last pair closes the block
    function automatic void account_pair(input logic [COEF_W-1:0] coef,
                                         input logic [RUN_W-1:0] run,
                                         input logic last);
        int unsigned mag;
        int unsigned sum;
        // -32768 maps to 32768, which is still a legal level
        mag = coef[COEF_W-1] ? (32'h10000 - int'(coef)) : int'(coef);
        sum = int'(block_sum) + run_bits(int'(run), mag) + level_bits(mag);
        block_sum = sum[TOTAL_W-1:0];  // wraps modulo 4096
        if (last)
        begin
            block_bits_due.push_back(block_sum);
            block_sum = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued pairs, idles per word, honors hold entries
    // ------------------------------------------------------------------
    bit          offering  = 1'b0;
    int unsigned gap_count = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_pairs
        pair_word_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            offering  = 1'b0;
            gap_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                account_pair(s_tdata[COEF_W-1:0], s_tdata[COEF_W+RUN_W-1:COEF_W], s_tlast);
                offering = 1'b0;
            end
            if (!offering && pending_pairs.size() > 0)
            begin
                if (pending_pairs[0].hold)
                begin
                    // pause until every predicted total has come back
                    if (block_bits_due.size() == 0)
                        void'(pending_pairs.pop_front());
                end
                else if (gap_count < pending_pairs[0].gap)
                begin
                    gap_count++;
                end
                else
                begin
                    nxt = pending_pairs.pop_front();
                    s_tdata   <= {{(IN_DATA_W - COEF_W - RUN_W){1'b0}}, nxt.run, nxt.coef};
                    s_tlast   <= nxt.last;
                    offering   = 1'b1;
                    gap_count  = 0;
                end
            end
            s_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each total, stalls per word, one long hold-off
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin : watch_totals
        logic [TOTAL_W-1:0] want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (block_bits_due.size() == 0)
                begin
                    $error("block_bits: no total expected, actual %0d", m_tdata[TOTAL_W-1:0]);
                    mismatches++;
                end
                else
                begin
                    want = block_bits_due.pop_front();
                    if (m_tdata[TOTAL_W-1:0] !== want)
                    begin
                        $error("block_bits: expected %0d, actual %0d",
                               want, m_tdata[TOTAL_W-1:0]);
                        mismatches++;
                    end
                end
                if (m_tdata[OUT_DATA_W-1:TOTAL_W] !== '0)
                begin
                    $error("tdata pad: expected 0, actual %0h", m_tdata[OUT_DATA_W-1:TOTAL_W]);
                    mismatches++;
                end
                totals_seen++;
                // long back-pressure so the queue fills and s_tready drops
                if (totals_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                // every third window of 30 totals runs without stalls
                stall_left = (((totals_seen / 30) % 3) == 1) ? 0 : $urandom_range(0, 12);
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            m_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_pair(input logic [COEF_W-1:0] coef,
                                       input logic [RUN_W-1:0] run,
                                       input logic last,
                                       input int unsigned gap);
        pair_word_t w;
        w.coef = coef;
        w.run  = run;
        w.last = last;
        w.gap  = gap;
        w.hold = 1'b0;
        pending_pairs.push_back(w);
    endfunction

    function automatic void queue_hold();
        pair_word_t w;
        w.coef = '0;
        w.run  = '0;
        w.last = 1'b0;
        w.gap  = 0;
        w.hold = 1'b1;
        pending_pairs.push_back(w);
    endfunction

    function automatic logic [COEF_W-1:0] draw_coef(input bit big);
        logic [COEF_W-1:0] v;
        int unsigned       kind;
        kind = big ? 2 : $urandom_range(0, 5);
        case (kind)
            0: v = '0;
            1: v = COEF_W'($signed($urandom_range(0, 18)) - 9);
            2: v = COEF_W'($urandom_range(0, 16'hFFFF));
            3: v = $urandom_range(0, 1) ? COEF_W'($urandom_range(9, 600))
                                         : COEF_W'(-$signed($urandom_range(9, 600)));
            4:
            begin
                case ($urandom_range(0, 5))
                    0: v = 16'h8000;           // most negative
                    1: v = 16'h7FFF;
                    2: v = 16'd4104;           // a - 9 = 4095: order capped
                    3: v = 16'd4105;           // order saturates
                    4: v = -16'sd4105;
                    default: v = 16'd520;      // a - 9 = 511
                endcase
            end
            default: v = COEF_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [RUN_W-1:0] draw_run();
        logic [RUN_W-1:0] r;
        case ($urandom_range(0, 3))
            0: r = '0;
            1: r = RUN_W'($urandom_range(1, 15));
            2: r = RUN_W'($urandom_range(16, 40));
            default: r = RUN_W'($urandom_range(0, 1023));
        endcase
        return r;
    endfunction

    initial
    begin : run_test
        int unsigned n;
        int unsigned len;
        int unsigned gap;
        bit          big;
        logic        last;

        // directed: level and run extremes, in short blocks
        queue_pair(16'd0,    10'd0,    1'b1, 0);  // zero level, zero run
        queue_pair(16'd1,    10'd0,    1'b0, 0);
        queue_pair(16'd8,    10'd15,   1'b0, 0);
        queue_pair(16'd9,    10'd16,   1'b1, 0);  // both escapes at their thresholds
        queue_pair(16'd10,   10'd17,   1'b1, 3);
        queue_pair(-16'sd1,  10'd1,    1'b1, 0);
        queue_pair(16'h8000, 10'd1023, 1'b1, 0);  // most negative coefficient, longest run
        queue_pair(16'h7FFF, 10'd0,    1'b1, 12);
        queue_pair(16'd520,  10'd527,  1'b1, 0);  // order of 511 on both parts
        queue_pair(16'd4104, 10'd0,    1'b1, 0);  // a - 9 = 4095: order capped
        queue_pair(16'd4103, 10'd0,    1'b1, 0);  // a - 9 = 4094
        queue_pair(-16'sd8,  10'd2,    1'b0, 1);
        queue_pair(16'd0,    10'd5,    1'b0, 0);  // run with zero level
        queue_pair(16'd3,    10'd0,    1'b1, 0);
        // total wrap: one block of maximal-cost pairs
        for (n = 0; n < WRAP_PAIRS; n++)
            queue_pair(16'h8000, 10'd1023, n == WRAP_PAIRS - 1, 0);
        queue_hold();

        // random blocks: mostly short, some long enough to wrap the total
        n = 0;
        while (n < RANDOM_PAIRS)
        begin
            big = ($urandom_range(0, 9) == 0);
            len = big ? $urandom_range(40, 90) : $urandom_range(1, 8);
            for (int unsigned k = 0; k < len; k++)
            begin
                last = (k == len - 1);
                gap  = (((n / 60) % 3) == 0) ? 0 : $urandom_range(0, 12);
                queue_pair(draw_coef(big), big ? RUN_W'($urandom_range(0, 1023)) : draw_run(),
                           last, gap);
                n++;
            end
            if ($urandom_range(0, 14) == 0 || n / 300 != (n - len) / 300)
                queue_hold();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() > 0 || s_tvalid)
            @(posedge clk);
        n = 0;
        while (block_bits_due.size() > 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (block_bits_due.size() > 0)
        begin
            $error("block_bits: %0d totals never arrived", block_bits_due.size());
            mismatches++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
